// ----- sv/u8p_pkg.sv -----
// Shared types, character constants and the replacement table of the punctuation normaliser.
`default_nettype none
package u8p_pkg;

  localparam int unsigned MaxRes = 4;

  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_DQUOTE = 8'h22;
  localparam logic [7:0] CHAR_SQUOTE = 8'h27;
  localparam logic [7:0] CHAR_STAR = 8'h2A;
  localparam logic [7:0] CHAR_HYPHEN = 8'h2D;
  localparam logic [7:0] CHAR_DOT = 8'h2E;

  localparam logic [2:0] LEN_NONE = 3'd0;
  localparam logic [2:0] LEN_TWO = 3'd2;
  localparam logic [2:0] LEN_THREE = 3'd3;
  localparam logic [2:0] LEN_FOUR = 3'd4;

  // Replacement for one completed character
  typedef struct packed {
    logic       hit;
    logic [1:0] num;
    logic [7:0] ch;
  } rep_t;

  // Result group caused by one input byte; bytes[0] goes out first
  typedef struct packed {
    logic [MaxRes-1:0][7:0] bytes;
    logic [2:0]             num;
    logic                   vld;
    logic                   fin;
  } res_t;

  function automatic logic [2:0] lead_len(input logic [7:0] b);
    logic [2:0] n;
    n = LEN_NONE;
    if (b[7:5] == 3'b110) n = LEN_TWO;
    else if (b[7:4] == 4'b1110) n = LEN_THREE;
    else if (b[7:3] == 5'b11110) n = LEN_FOUR;
    return n;
  endfunction

  function automatic rep_t mk_rep(input logic [1:0] num, input logic [7:0] ch);
    rep_t r;
    r.hit = 1'b1;
    r.num = num;
    r.ch  = ch;
    return r;
  endfunction

  function automatic rep_t rep_lookup(input logic [2:0] len, input logic [23:0] seq);
    rep_t r;
    r = '0;
    if (len == LEN_TWO) begin
      case (seq[15:0])
        16'hC2A0: r = mk_rep(2'd1, CHAR_SPACE);
        16'hC2AD: r = mk_rep(2'd0, 8'h00);
        16'hC2B7: r = mk_rep(2'd1, CHAR_STAR);
        default:  r = '0;
      endcase
    end else if (len == LEN_THREE) begin
      if (seq >= 24'hE28080 && seq <= 24'hE2808A) r = mk_rep(2'd1, CHAR_SPACE);
      else if (seq >= 24'hE2808B && seq <= 24'hE2808F) r = mk_rep(2'd0, 8'h00);
      else if (seq >= 24'hE28090 && seq <= 24'hE28095) r = mk_rep(2'd1, CHAR_HYPHEN);
      else begin
        case (seq)
          24'hE2809C, 24'hE2809D: r = mk_rep(2'd1, CHAR_DQUOTE);
          24'hE28098, 24'hE28099: r = mk_rep(2'd1, CHAR_SQUOTE);
          24'hE28892:             r = mk_rep(2'd1, CHAR_HYPHEN);
          24'hE280A6:             r = mk_rep(2'd3, CHAR_DOT);
          24'hE280AF, 24'hE19A80, 24'hE2819F, 24'hE38080:
                                  r = mk_rep(2'd1, CHAR_SPACE);
          24'hE281A0, 24'hEFBBBF: r = mk_rep(2'd0, 8'h00);
          24'hE280A2, 24'hE280A3, 24'hE296AA, 24'hE28B85:
                                  r = mk_rep(2'd1, CHAR_STAR);
          default:                r = '0;
        endcase
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- sv/u8p_decode.sv -----
// Sequence holding state and single-pass decode of one byte into its result group.
`default_nettype none
module u8p_decode (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          acc,
  input  wire logic [7:0]    in_byte,
  input  wire logic          in_end,
  output u8p_pkg::res_t      res
);
  import u8p_pkg::*;

  logic [23:0] pend;
  logic [1:0]  cnt;
  logic [2:0]  exp_len;
  logic [23:0] pend_next;
  logic [1:0]  cnt_next;
  logic [2:0]  exp_len_next;

  logic        has_p, cont_path, complete;
  logic [2:0]  len;
  logic [2:0]  lead_n;
  logic [31:0] seq, raw;
  logic [1:0]  shamt;
  rep_t        lk;
  logic [2:0]  raw_n;

  always_comb begin
    has_p     = (cnt != 2'd0);
    cont_path = has_p && (in_byte[7:6] == 2'b10);
    len       = {1'b0, cnt} + 3'd1;
    complete  = cont_path && (len >= exp_len);
    seq       = {pend, in_byte};
    lk        = rep_lookup(len, seq[23:0]);
    lead_n    = lead_len(in_byte);
    shamt     = 2'd3 - cnt;
    // left-align held bytes followed by the new byte
    raw       = seq << {shamt, 3'b000};
    raw_n     = {1'b0, cnt} + {2'b00, (lead_n == LEN_NONE) || in_end};
  end

  always_comb begin
    res.fin = in_end;
    res.vld = 1'b1;
    res.bytes = {raw[7:0], raw[15:8], raw[23:16], raw[31:24]};
    res.num = raw_n;
    if (complete && lk.hit) begin
      res.bytes = {8'h00, CHAR_DOT, CHAR_DOT, lk.ch};
      res.num   = {1'b0, lk.num};
    end else if (complete) begin
      res.num = len;
    end else if (cont_path) begin
      res.num = in_end ? len : 3'd0;
    end
    if (res.num == 3'd0 && in_end) begin
      res.num   = 3'd1;
      res.vld   = 1'b0;
      res.bytes = '0;
    end
  end

  always_comb begin
    pend_next    = '0;
    cnt_next     = 2'd0;
    exp_len_next = LEN_NONE;
    if (cont_path && !complete) begin
      pend_next    = {pend[15:0], in_byte};
      cnt_next     = cnt + 2'd1;
      exp_len_next = exp_len;
    end else if (!cont_path && lead_n != LEN_NONE) begin
      pend_next    = {16'h0000, in_byte};
      cnt_next     = 2'd1;
      exp_len_next = lead_n;
    end
    if (in_end) begin
      pend_next    = '0;
      cnt_next     = 2'd0;
      exp_len_next = LEN_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend    <= '0;
      cnt     <= 2'd0;
      exp_len <= LEN_NONE;
    end else if (acc) begin
      pend    <= pend_next;
      cnt     <= cnt_next;
      exp_len <= exp_len_next;
    end
  end

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    acc && in_end |=> cnt == 2'd0)
    else $error("held bytes survive end of text");
  a_held_lead: assert property (@(posedge clk) disable iff (rst)
    cnt != 2'd0 |-> {1'b0, cnt} < exp_len)
    else $error("held count reached announced length");
  a_marker_only_end: assert property (@(posedge clk) disable iff (rst)
    !res.vld |-> in_end && res.num == 3'd1)
    else $error("bare marker without end of text");

endmodule
`default_nettype wire

// ----- sv/u8p_burst.sv -----
// Result register that hands out a group of up to four bytes, one per cycle while res_ready is high.
`default_nettype none
module u8p_burst (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          load_req,
  input  wire u8p_pkg::res_t res,
  output logic               can_load,
  output logic               res_valid,
  input  wire logic          res_ready,
  output logic [7:0]         out_byte,
  output logic               out_valid,
  output logic               run_last,
  output logic               out_end
);
  import u8p_pkg::*;

  logic [MaxRes-1:0][7:0] bytes;
  logic [1:0]             last;
  logic [1:0]             idx;
  logic                   vld;
  logic                   fin;
  logic                   full;
  logic                   pop, done, load;

  always_comb begin
    res_valid = full;
    out_byte  = bytes[idx];
    out_valid = vld;
    run_last  = (idx == last);
    out_end   = run_last && fin;
    pop       = full && res_ready;
    done      = pop && run_last;
    can_load  = !full || done;
    load      = load_req && can_load && (res.num != 3'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
      idx  <= 2'd0;
    end else if (load) begin
      full <= 1'b1;
      idx  <= 2'd0;
    end else if (done) begin
      full <= 1'b0;
      idx  <= 2'd0;
    end else if (pop) begin
      idx <= idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bytes <= res.bytes;
      last  <= 2'(res.num - 3'd1);
      vld   <= res.vld;
      fin   <= res.fin;
    end
  end

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    full |-> idx <= last)
    else $error("transfer index past group end");
  a_idle_idx: assert property (@(posedge clk) disable iff (rst)
    !full |-> idx == 2'd0)
    else $error("index not cleared while empty");
  a_load_starts: assert property (@(posedge clk) disable iff (rst)
    load |=> full && idx == 2'd0)
    else $error("group load lost");

endmodule
`default_nettype wire

// ----- sv/utf8_punctuation_to_ascii.sv -----
// Top level of the UTF-8 punctuation normaliser.
// Input channel: in_valid/in_ready carry one text byte (in_byte) and an end flag (in_end).
// Output channel: res_valid/res_ready carry one result: out_byte, out_valid (0 only on a
// bare end marker), run_last (last result of its input byte) and out_end (last of the text).
// Bytes of a multi-byte character are held until it completes; it then leaves as its
// ASCII replacement, is dropped, or goes out unchanged. Broken sequences go out as is.
// Decode is a single combinational pass from the input port into a result register;
// the first result is visible in the cycle after the input transfer.
// Throughput: one input byte per cycle while each byte gives at most one result. A byte
// that gives more than one result (up to four: a flush plus the new byte, or an ellipsis)
// holds the input until the last of them transfers, since the result register hands out
// one byte per cycle. Bytes that give no result (held lead and continuation bytes, dropped
// marks) are taken without loading the result register. A stalled receiver holds the
// result register; a new byte is taken in the cycle the last pending result transfers.
// Reset (rst, synchronous) empties the held sequence and the result register.
`default_nettype none
module utf8_punctuation_to_ascii (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_end,
  output logic            res_valid,
  input  wire logic       res_ready,
  output logic [7:0]      out_byte,
  output logic            out_valid,
  output logic            run_last,
  output logic            out_end
);
  import u8p_pkg::*;

  res_t res;
  logic acc;

  assign acc = in_valid && in_ready;

  u8p_decode u_decode (
    .clk     (clk),
    .rst     (rst),
    .acc     (acc),
    .in_byte (in_byte),
    .in_end  (in_end),
    .res     (res)
  );

  u8p_burst u_burst (
    .clk       (clk),
    .rst       (rst),
    .load_req  (in_valid),
    .res       (res),
    .can_load  (in_ready),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .out_byte  (out_byte),
    .out_valid (out_valid),
    .run_last  (run_last),
    .out_end   (out_end)
  );

endmodule
`default_nettype wire
